/* rtl/core/bdse_pkg.sv */
package bdse_pkg;

   // Field widths fixed by the stream format
   localparam int OFF_W   = 12;
   localparam int VAL_W   = 8;
   localparam int CNT_W   = 16;
   localparam int LEN_W   = 13;
   localparam int TOTAL_W = 7;
   localparam int DELTA_W = 17;

   // Bus widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   // Offsets are 12 bits and the region is at least 16 bytes, so the
   // wrap needs at most eight conditional subtract steps
   localparam int QUOT_BITS = 8;

   // Run length saturates here
   localparam logic [LEN_W-1:0] RUN_LEN_MAX = 13'h1FFF;

   // Input mode codes
   localparam logic MODE_COMPARE = 1'b0;
   localparam logic MODE_LOAD    = 1'b1;

   // Result kind codes
   localparam logic KIND_SPAN    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic                      kind;
      logic [OFF_W-1:0]          span_start;
      logic [LEN_W-1:0]          span_length;
      logic [TOTAL_W-1:0]        span_total;
      logic                      overflowed;
      logic signed [DELTA_W-1:0] counter_delta;
      logic                      anything_changed;
      logic                      last;
   } result_type;

endpackage

/* rtl/core/bdse_ram.sv */
module bdse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read that holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/byte_delta_span_encoder.sv */
// Each byte is registered in stage 1, which writes its results into the
// result queue that rsp offers from. Throughput: one byte per cycle while the
// queue has room for two results; an item that closes a span at pass end gives
// two results, which leave the output one per cycle while rsp_tready is high.
// Reset (synchronous): run, span and counter state clear, then a clearing pass
// zeroes the baseline memory, one entry a cycle, with req_tready low until it is done.
module byte_delta_span_encoder #(
   parameter int REGION_BYTES = 4096,
   parameter int MAX_SPANS    = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // byte_offset[11:0], byte_value[19:12], range_end[20], counter_value[36:21]
   input  logic [bdse_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                            req_tuser,
   // pass_end
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // span_start[11:0], span_length[24:12], span_total[31:25], overflowed[32],
   // counter_delta[49:33], anything_changed[50]
   output logic [bdse_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind
   output logic                            rsp_tuser,
   // last
   output logic                            rsp_tlast
);

   localparam int IDX_W  = $clog2(REGION_BYTES);
   localparam int SPAN_W = $clog2(MAX_SPANS + 1);

   // Offset wrap into the region by restoring subtract steps
   function automatic logic [bdse_pkg::OFF_W-1:0] wrap_offset(
      input logic [bdse_pkg::OFF_W-1:0] off
   );
      logic [bdse_pkg::OFF_W-1:0] rem;
      rem = off;
      for (int b = bdse_pkg::QUOT_BITS - 1; b >= 0; b--) begin
         if ((REGION_BYTES << b) < (1 << bdse_pkg::OFF_W)) begin
            if (rem >= bdse_pkg::OFF_W'(REGION_BYTES << b)) begin
               rem = rem - bdse_pkg::OFF_W'(REGION_BYTES << b);
            end
         end
      end
      return rem;
   endfunction

   // Input field unpacking
   logic [bdse_pkg::OFF_W-1:0] in_off;
   logic [bdse_pkg::VAL_W-1:0] in_val;
   logic                       in_rend;
   logic [bdse_pkg::CNT_W-1:0] in_cv;
   logic [IDX_W-1:0]           in_idx;
   logic                       accept;

   assign in_off  = req_tdata[11:0];
   assign in_val  = req_tdata[19:12];
   assign in_rend = req_tdata[20];
   assign in_cv   = req_tdata[36:21];
   assign in_idx  = IDX_W'(wrap_offset(in_off));

   // Clearing pass after reset
   logic             clr_active_ff, clr_active_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == IDX_W'(REGION_BYTES - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // Item register (stage 1) alongside the baseline read
   logic                       s1_valid_ff;
   logic                       s1_mode_ff;
   logic [bdse_pkg::OFF_W-1:0] s1_off_ff;
   logic [IDX_W-1:0]           s1_idx_ff;
   logic [bdse_pkg::VAL_W-1:0] s1_val_ff;
   logic                       s1_rend_ff;
   logic                       s1_pend_ff;
   logic [bdse_pkg::CNT_W-1:0] s1_cv_ff;
   logic                       fwd_hit_ff;
   logic [bdse_pkg::VAL_W-1:0] fwd_data_ff;
   logic                       s1_fire;
   logic                       fwd_hit_in;

   assign req_tready = !clr_active_ff && (!s1_valid_ff || s1_fire);
   assign accept     = req_tvalid && req_tready;

   // The byte written by stage 1 in this same cycle is not yet in the
   // memory read, so it is carried along with the new item
   assign fwd_hit_in = s1_fire && (s1_idx_ff == in_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_tuser;
         s1_off_ff   <= in_off;
         s1_idx_ff   <= in_idx;
         s1_val_ff   <= in_val;
         s1_rend_ff  <= in_rend;
         s1_pend_ff  <= req_tlast;
         s1_cv_ff    <= in_cv;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= s1_val_ff;
      end
   end

   // Baseline memory: clearing pass or stage 1 owns the write port
   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [bdse_pkg::VAL_W-1:0] ram_wr_data;
   logic [bdse_pkg::VAL_W-1:0] ram_rd_data;

   assign ram_wr_en   = clr_active_ff || s1_fire;
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wr_data = clr_active_ff ? '0 : s1_val_ff;

   bdse_ram #(
      .WIDTH (bdse_pkg::VAL_W),
      .DEPTH (REGION_BYTES)
   ) u_baseline (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (in_idx),
      .rd_data (ram_rd_data)
   );

   // Run and pass state
   logic                       run_open_ff, run_open_in;
   logic [bdse_pkg::OFF_W-1:0] run_start_ff, run_start_in;
   logic [bdse_pkg::LEN_W-1:0] run_length_ff, run_length_in;
   logic [SPAN_W-1:0]          spans_ff, spans_in;
   logic                       overflow_ff, overflow_in;
   logic [bdse_pkg::CNT_W-1:0] cbase_ff, cbase_in;

   // Stage 1 work
   logic [bdse_pkg::VAL_W-1:0]   base_byte;
   logic                         differs;
   logic                         close_run;
   logic                         emit_span;
   logic                         emit_sum;
   logic [bdse_pkg::OFF_W-1:0]   span_start;
   logic [bdse_pkg::LEN_W-1:0]   span_length;
   logic [SPAN_W-1:0]            spans_upd;
   logic                         overflow_upd;
   logic [bdse_pkg::DELTA_W-1:0] delta;
   bdse_pkg::result_type         span_res;
   bdse_pkg::result_type         sum_res;
   bdse_pkg::result_type         slot_a;
   logic [1:0]                   push_n;

   assign base_byte = fwd_hit_ff ? fwd_data_ff : ram_rd_data;

   always_comb begin
      differs = (base_byte != s1_val_ff);

      // Run after this byte, before any close
      if (differs) begin
         span_start = run_open_ff ? run_start_ff : s1_off_ff;
         if (!run_open_ff) begin
            span_length = bdse_pkg::LEN_W'(1);
         end else if (run_length_ff < bdse_pkg::RUN_LEN_MAX) begin
            span_length = run_length_ff + bdse_pkg::LEN_W'(1);
         end else begin
            span_length = run_length_ff;
         end
      end else begin
         span_start  = run_start_ff;
         span_length = run_length_ff;
      end

      // A match closes the open run; a differing byte closes it at range end or pass end
      close_run    = differs ? (s1_rend_ff || s1_pend_ff) : run_open_ff;
      close_run    = close_run && (s1_mode_ff == bdse_pkg::MODE_COMPARE);
      emit_span    = close_run && (spans_ff < SPAN_W'(MAX_SPANS));
      emit_sum     = s1_pend_ff && (s1_mode_ff == bdse_pkg::MODE_COMPARE);
      spans_upd    = emit_span ? spans_ff + SPAN_W'(1) : spans_ff;
      overflow_upd = overflow_ff || (close_run && !emit_span);
      delta        = {1'b0, s1_cv_ff} - {1'b0, cbase_ff};

      span_res                  = '0;
      span_res.kind             = bdse_pkg::KIND_SPAN;
      span_res.span_start       = span_start;
      span_res.span_length      = span_length;

      sum_res                   = '0;
      sum_res.kind              = bdse_pkg::KIND_SUMMARY;
      sum_res.span_total        = bdse_pkg::TOTAL_W'(spans_upd);
      sum_res.overflowed        = overflow_upd;
      sum_res.counter_delta     = delta;
      sum_res.anything_changed  = (spans_upd != '0) || overflow_upd || (delta != '0);
      sum_res.last              = 1'b1;

      push_n = {1'b0, emit_span} + {1'b0, emit_sum};
      slot_a = emit_span ? span_res : sum_res;
      slot_a.last = (push_n == 2'd1);

      // Next state
      run_open_in   = run_open_ff;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      spans_in      = spans_ff;
      overflow_in   = overflow_ff;
      cbase_in      = cbase_ff;
      if (s1_mode_ff == bdse_pkg::MODE_LOAD) begin
         if (s1_pend_ff) begin
            cbase_in = s1_cv_ff;
         end
      end else if (s1_pend_ff) begin
         run_open_in   = 1'b0;
         run_start_in  = '0;
         run_length_in = '0;
         spans_in      = '0;
         overflow_in   = 1'b0;
         cbase_in      = s1_cv_ff;
      end else if (close_run) begin
         run_open_in   = 1'b0;
         run_start_in  = '0;
         run_length_in = '0;
         spans_in      = spans_upd;
         overflow_in   = overflow_upd;
      end else if (differs) begin
         run_open_in   = 1'b1;
         run_start_in  = span_start;
         run_length_in = span_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         spans_ff      <= '0;
         overflow_ff   <= 1'b0;
         cbase_ff      <= '0;
      end else if (s1_fire) begin
         run_open_ff   <= run_open_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         spans_ff      <= spans_in;
         overflow_ff   <= overflow_in;
         cbase_ff      <= cbase_in;
      end
   end

   // Result queue: stage 1 fires only with room for two results
   bdse_pkg::result_type          q_ff [bdse_pkg::QDEPTH];
   logic [bdse_pkg::QPTR_W-1:0]   q_wr_ff, q_wr_in;
   logic [bdse_pkg::QPTR_W-1:0]   q_rd_ff, q_rd_in;
   logic [bdse_pkg::QCNT_W-1:0]   q_cnt_ff, q_cnt_in;
   logic                          pop;
   logic [bdse_pkg::QCNT_W-1:0]   push_cnt;

   assign s1_fire  = s1_valid_ff && (q_cnt_ff <= bdse_pkg::QCNT_W'(bdse_pkg::QDEPTH - 2));
   assign pop      = rsp_tvalid && rsp_tready;
   assign push_cnt = s1_fire ? bdse_pkg::QCNT_W'(push_n) : '0;

   always_comb begin
      q_wr_in  = q_wr_ff + bdse_pkg::QPTR_W'(push_cnt);
      q_rd_in  = pop ? q_rd_ff + bdse_pkg::QPTR_W'(1) : q_rd_ff;
      q_cnt_in = q_cnt_ff + push_cnt - bdse_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && push_n != 2'd0) begin
         q_ff[q_wr_ff] <= slot_a;
      end
      if (s1_fire && push_n == 2'd2) begin
         q_ff[q_wr_ff + bdse_pkg::QPTR_W'(1)] <= sum_res;
      end
   end

   // Output packing
   bdse_pkg::result_type head;

   assign head       = q_ff[q_rd_ff];
   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {5'b0, head.anything_changed, head.counter_delta, head.overflowed,
                        head.span_total, head.span_length, head.span_start};

endmodule
